[hw/rtl/a1_cell_reference_parser_macros.svh]
// assertion macros for the a1 cell reference parser
`ifndef A1_CELL_REFERENCE_PARSER_MACROS_SVH
`define A1_CELL_REFERENCE_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define A1CRP_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("a1crp check failed");
`define A1CRP_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("a1crp check failed");
`else
`define A1CRP_ASSERT_NEVER(lbl, expr)
`define A1CRP_ASSERT_IMPLY(lbl, ante, cons)
`endif
`endif

[hw/rtl/a1crp_pkg.sv]
// shared types and constants for the a1 cell reference parser
package a1crp_pkg;

    localparam int ROW_W        = 20;
    localparam int COL_W        = 14;
    localparam int NAME_W       = 9;
    localparam int COLACC_W     = 15;
    localparam int ROWACC_W     = 21;
    localparam int LCNT_W       = 3;
    localparam int DCNT_W       = 4;
    localparam int MAX_ROWS_DEF = 1048576;
    localparam int MAX_COLS_DEF = 16384;
    localparam int NAME_CAP_DEF = 256;
    localparam int MAX_LETTERS  = 3;
    localparam int MAX_DIGITS   = 7;
    localparam int COL_RADIX    = 26;
    localparam int ROW_RADIX    = 10;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } in_word_t;

    typedef struct packed {
        logic              ref_valid;
        logic              range_shape;
        logic              whole_column;
        logic              whole_row;
        logic              has_sheet;
        logic              sheet_quoted;
        logic [NAME_W-1:0] sheet_name_length;
        logic [ROW_W-1:0]  first_row;
        logic [COL_W-1:0]  first_col;
        logic [ROW_W-1:0]  second_row;
        logic [COL_W-1:0]  second_col;
    } out_word_t;

    typedef struct packed {
        logic       last;
        logic       is_alpha;
        logic       is_num;
        logic       is_dollar;
        logic       is_colon;
        logic       is_quote;
        logic       is_bang;
        logic       is_under;
        logic [4:0] letter_val;
        logic [3:0] digit_val;
    } cls_t;

    typedef enum logic [17:0] {
        PH_BEGIN    = 18'h00001,
        PH_START    = 18'h00002,
        PH_LEAD_D   = 18'h00004,
        PH_COL1     = 18'h00008,
        PH_COL1_D   = 18'h00010,
        PH_ROW1     = 18'h00020,
        PH_FROW1    = 18'h00040,
        PH_CCOLON   = 18'h00080,
        PH_CCOLON_D = 18'h00100,
        PH_COL2C    = 18'h00200,
        PH_RCOLON   = 18'h00400,
        PH_RCOLON_D = 18'h00800,
        PH_ROW2R    = 18'h01000,
        PH_ECOLON   = 18'h02000,
        PH_ECOLON_D = 18'h04000,
        PH_COL2E    = 18'h08000,
        PH_COL2E_D  = 18'h10000,
        PH_ROW2E    = 18'h20000
    } phase_t;

    typedef enum logic [2:0] {
        Q_NONE = 3'b001,
        Q_IN   = 3'b010,
        Q_END  = 3'b100
    } qphase_t;

endpackage

[hw/rtl/a1crp_front.sv]
// front end: classifies each incoming character word
module a1crp_front (
    input  a1crp_pkg::in_word_t text,
    output a1crp_pkg::cls_t     cls
);

    logic [7:0] ch;
    logic [7:0] upper;

    assign ch    = text.text_char;
    assign upper = (ch >= 8'h61) ? (ch - 8'd32) : ch;

    always_comb
    begin
        cls.last       = text.last_char;
        cls.is_alpha   = (ch inside {[8'h41:8'h5A], [8'h61:8'h7A]});
        cls.is_num     = (ch inside {[8'h30:8'h39]});
        cls.is_dollar  = (ch == a1crp_pkg::CH_DOLLAR);
        cls.is_colon   = (ch == a1crp_pkg::CH_COLON);
        cls.is_quote   = (ch == a1crp_pkg::CH_QUOTE);
        cls.is_bang    = (ch == a1crp_pkg::CH_BANG);
        cls.is_under   = (ch == a1crp_pkg::CH_UNDER);
        cls.letter_val = 5'(upper - 8'h40);
        cls.digit_val  = 4'(ch - 8'h30);
    end

endmodule

[hw/rtl/a1crp_queue.sv]
// short queue between the classifier and the parser
module a1crp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  a1crp_pkg::cls_t push_word,
    output logic            pop_valid,
    input  logic            pop_ready,
    output a1crp_pkg::cls_t pop_word
);

    localparam int PTR_W = $clog2(a1crp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(a1crp_pkg::QUEUE_DEPTH + 1);

    a1crp_pkg::cls_t    mem_reg [a1crp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(a1crp_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(a1crp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(a1crp_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hw/rtl/a1crp_back.sv]
// back end: reference parse state machine and result register
module a1crp_back #(
    parameter int MAX_ROWS = a1crp_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = a1crp_pkg::MAX_COLS_DEF,
    parameter int NAME_CAP = a1crp_pkg::NAME_CAP_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  a1crp_pkg::cls_t      q_word,
    output logic                 result_valid,
    input  logic                 result_ready,
    output a1crp_pkg::out_word_t result
);

    localparam int ROW_W    = a1crp_pkg::ROW_W;
    localparam int COL_W    = a1crp_pkg::COL_W;
    localparam int NAME_W   = a1crp_pkg::NAME_W;
    localparam int CACC_W   = a1crp_pkg::COLACC_W;
    localparam int RACC_W   = a1crp_pkg::ROWACC_W;
    localparam int LCNT_W   = a1crp_pkg::LCNT_W;
    localparam int DCNT_W   = a1crp_pkg::DCNT_W;
    localparam int CWIDE_W  = CACC_W + 5;
    localparam int RWIDE_W  = RACC_W + 4;

    a1crp_pkg::phase_t  ph_reg, ph_next;
    a1crp_pkg::qphase_t qp_reg, qp_next;
    logic               bare_reg, bare_next;
    logic [NAME_W-1:0]  name_reg, name_next;
    logic [LCNT_W-1:0]  lcnt_reg, lcnt_next;
    logic [DCNT_W-1:0]  dcnt_reg, dcnt_next;
    logic [CACC_W-1:0]  col_reg, col_next;
    logic [RACC_W-1:0]  row_reg, row_next;
    logic [ROW_W-1:0]   frow_reg, frow_next;
    logic [COL_W-1:0]   fcol_reg, fcol_next;
    logic               err_reg, err_next;
    logic               sheet_reg, sheet_next;
    logic               quoted_reg, quoted_next;
    logic                 out_valid_reg;
    a1crp_pkg::out_word_t out_reg, out_next;

    a1crp_pkg::cls_t    c;
    a1crp_pkg::phase_t  p;
    logic               take;
    logic               skip, restart, do_name, do_letter, do_digit, do_clear;
    logic [LCNT_W-1:0]  lcnt1;
    logic [DCNT_W-1:0]  dcnt1;
    logic [CWIDE_W-1:0] cwide;
    logic [RWIDE_W-1:0] rwide;
    logic               lbad, dbad;
    logic [ROW_W-1:0]   row_m1;
    logic [COL_W-1:0]   col_m1;

    assign c       = q_word;
    assign q_ready = !c.last || !out_valid_reg || result_ready;
    assign take    = q_valid && q_ready;

    assign lcnt1 = lcnt_reg + 1'b1;
    assign dcnt1 = dcnt_reg + 1'b1;
    assign cwide = CWIDE_W'(col_reg) * CWIDE_W'(a1crp_pkg::COL_RADIX) + CWIDE_W'(c.letter_val);
    assign rwide = RWIDE_W'(row_reg) * RWIDE_W'(a1crp_pkg::ROW_RADIX) + RWIDE_W'(c.digit_val);
    assign lbad  = (lcnt1 > LCNT_W'(a1crp_pkg::MAX_LETTERS)) || (cwide > CWIDE_W'(MAX_COLS));
    assign dbad  = (dcnt1 > DCNT_W'(a1crp_pkg::MAX_DIGITS)) || (rwide > RWIDE_W'(MAX_ROWS));

    // character step
    always_comb
    begin
        ph_next     = ph_reg;
        qp_next     = qp_reg;
        bare_next   = bare_reg;
        name_next   = name_reg;
        lcnt_next   = lcnt_reg;
        dcnt_next   = dcnt_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        frow_next   = frow_reg;
        fcol_next   = fcol_reg;
        err_next    = err_reg;
        sheet_next  = sheet_reg;
        quoted_next = quoted_reg;
        skip        = 1'b0;
        restart     = 1'b0;
        do_name     = 1'b0;
        do_letter   = 1'b0;
        do_digit    = 1'b0;
        do_clear    = 1'b0;
        p           = ph_reg;

        if (ph_reg == a1crp_pkg::PH_BEGIN)
        begin
            ph_next = a1crp_pkg::PH_START;
            if (c.is_quote)
            begin
                bare_next   = 1'b0;
                qp_next     = a1crp_pkg::Q_IN;
                sheet_next  = 1'b1;
                quoted_next = 1'b1;
                skip        = 1'b1;
            end
        end

        if (!skip)
        begin
            if (qp_reg == a1crp_pkg::Q_IN)
            begin
                skip = 1'b1;
                if (c.is_quote)
                begin
                    qp_next = a1crp_pkg::Q_END;
                end
                else
                begin
                    do_name = 1'b1;
                end
            end
            else if (qp_reg == a1crp_pkg::Q_END)
            begin
                skip = 1'b1;
                if (c.is_quote)
                begin
                    do_name = 1'b1;
                    qp_next = a1crp_pkg::Q_IN;
                end
                else
                begin
                    qp_next = a1crp_pkg::Q_NONE;
                    if (!c.is_bang)
                    begin
                        err_next = 1'b1;
                    end
                end
            end
            else if (bare_reg)
            begin
                if (c.is_alpha || c.is_num || c.is_under)
                begin
                    do_name = 1'b1;
                end
                else if (c.is_bang && name_reg != '0)
                begin
                    sheet_next = 1'b1;
                    bare_next  = 1'b0;
                    restart    = 1'b1;
                    skip       = 1'b1;
                end
                else
                begin
                    bare_next = 1'b0;
                    name_next = '0;
                end
            end
        end

        if (do_name && (32'(name_reg) < NAME_CAP))
        begin
            name_next = name_reg + 1'b1;
        end

        if (!skip && !err_reg)
        begin
            p = ph_next;
            case (p)
                a1crp_pkg::PH_START, a1crp_pkg::PH_LEAD_D:
                begin
                    if (c.is_dollar && p == a1crp_pkg::PH_START)
                    begin
                        ph_next = a1crp_pkg::PH_LEAD_D;
                    end
                    else if (c.is_alpha)
                    begin
                        do_letter = 1'b1;
                        ph_next   = a1crp_pkg::PH_COL1;
                    end
                    else if (c.is_num)
                    begin
                        do_digit = 1'b1;
                        ph_next  = a1crp_pkg::PH_FROW1;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                a1crp_pkg::PH_COL1:
                begin
                    if (c.is_alpha)
                    begin
                        do_letter = 1'b1;
                    end
                    else if (c.is_colon)
                    begin
                        fcol_next = COL_W'(col_reg - 1'b1);
                        do_clear  = 1'b1;
                        ph_next   = a1crp_pkg::PH_CCOLON;
                    end
                    else if (c.is_dollar)
                    begin
                        ph_next = a1crp_pkg::PH_COL1_D;
                    end
                    else if (c.is_num)
                    begin
                        do_digit = 1'b1;
                        ph_next  = a1crp_pkg::PH_ROW1;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                a1crp_pkg::PH_COL1_D, a1crp_pkg::PH_COL2E_D:
                begin
                    if (c.is_num)
                    begin
                        do_digit = 1'b1;
                        ph_next  = (p == a1crp_pkg::PH_COL1_D) ? a1crp_pkg::PH_ROW1
                                                               : a1crp_pkg::PH_ROW2E;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                a1crp_pkg::PH_ROW1:
                begin
                    if (c.is_num)
                    begin
                        do_digit = 1'b1;
                    end
                    else if (c.is_colon && row_reg != '0)
                    begin
                        frow_next = ROW_W'(row_reg - 1'b1);
                        fcol_next = COL_W'(col_reg - 1'b1);
                        do_clear  = 1'b1;
                        ph_next   = a1crp_pkg::PH_ECOLON;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                a1crp_pkg::PH_FROW1:
                begin
                    if (c.is_num)
                    begin
                        do_digit = 1'b1;
                    end
                    else if (c.is_colon && row_reg != '0)
                    begin
                        frow_next = ROW_W'(row_reg - 1'b1);
                        do_clear  = 1'b1;
                        ph_next   = a1crp_pkg::PH_RCOLON;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                a1crp_pkg::PH_CCOLON, a1crp_pkg::PH_ECOLON:
                begin
                    if (c.is_dollar)
                    begin
                        ph_next = (p == a1crp_pkg::PH_CCOLON) ? a1crp_pkg::PH_CCOLON_D
                                                              : a1crp_pkg::PH_ECOLON_D;
                    end
                    else if (c.is_alpha)
                    begin
                        do_letter = 1'b1;
                        ph_next   = (p == a1crp_pkg::PH_CCOLON) ? a1crp_pkg::PH_COL2C
                                                                : a1crp_pkg::PH_COL2E;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                a1crp_pkg::PH_CCOLON_D, a1crp_pkg::PH_ECOLON_D:
                begin
                    if (c.is_alpha)
                    begin
                        do_letter = 1'b1;
                        ph_next   = (p == a1crp_pkg::PH_CCOLON_D) ? a1crp_pkg::PH_COL2C
                                                                  : a1crp_pkg::PH_COL2E;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                a1crp_pkg::PH_RCOLON, a1crp_pkg::PH_RCOLON_D:
                begin
                    if (c.is_dollar && p == a1crp_pkg::PH_RCOLON)
                    begin
                        ph_next = a1crp_pkg::PH_RCOLON_D;
                    end
                    else if (c.is_num)
                    begin
                        do_digit = 1'b1;
                        ph_next  = a1crp_pkg::PH_ROW2R;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                a1crp_pkg::PH_COL2C:
                begin
                    if (c.is_alpha)
                    begin
                        do_letter = 1'b1;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                a1crp_pkg::PH_ROW2R, a1crp_pkg::PH_ROW2E:
                begin
                    if (c.is_num)
                    begin
                        do_digit = 1'b1;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                a1crp_pkg::PH_COL2E:
                begin
                    if (c.is_alpha)
                    begin
                        do_letter = 1'b1;
                    end
                    else if (c.is_dollar)
                    begin
                        ph_next = a1crp_pkg::PH_COL2E_D;
                    end
                    else if (c.is_num)
                    begin
                        do_digit = 1'b1;
                        ph_next  = a1crp_pkg::PH_ROW2E;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                default:
                begin
                    err_next = 1'b1;
                end
            endcase
        end

        if (do_letter)
        begin
            lcnt_next = lcnt1;
            if (lbad)
            begin
                err_next = 1'b1;
            end
            else
            begin
                col_next = CACC_W'(cwide);
            end
        end
        if (do_digit)
        begin
            dcnt_next = dcnt1;
            if (dbad)
            begin
                err_next = 1'b1;
            end
            else
            begin
                row_next = RACC_W'(rwide);
            end
        end
        if (do_clear || restart)
        begin
            lcnt_next = '0;
            dcnt_next = '0;
            col_next  = '0;
            row_next  = '0;
        end
        if (restart)
        begin
            ph_next   = a1crp_pkg::PH_START;
            frow_next = '0;
            fcol_next = '0;
            err_next  = 1'b0;
        end
    end

    assign row_m1 = ROW_W'(row_next - 1'b1);
    assign col_m1 = COL_W'(col_next - 1'b1);

    // end of string result
    always_comb
    begin
        out_next = '0;
        if (!err_next && qp_next == a1crp_pkg::Q_NONE)
        begin
            if (ph_next == a1crp_pkg::PH_ROW1 && row_next != '0)
            begin
                out_next.ref_valid = 1'b1;
                out_next.first_row = row_m1;
                out_next.first_col = col_m1;
            end
            else if (ph_next == a1crp_pkg::PH_COL2C)
            begin
                out_next.ref_valid    = 1'b1;
                out_next.range_shape  = 1'b1;
                out_next.whole_column = 1'b1;
                out_next.first_col    = (fcol_next < col_m1) ? fcol_next : col_m1;
                out_next.second_col   = (fcol_next < col_m1) ? col_m1 : fcol_next;
                out_next.second_row   = ROW_W'(MAX_ROWS - 1);
            end
            else if (ph_next == a1crp_pkg::PH_ROW2R && row_next != '0)
            begin
                out_next.ref_valid   = 1'b1;
                out_next.range_shape = 1'b1;
                out_next.whole_row   = 1'b1;
                out_next.first_row   = (frow_next < row_m1) ? frow_next : row_m1;
                out_next.second_row  = (frow_next < row_m1) ? row_m1 : frow_next;
                out_next.second_col  = COL_W'(MAX_COLS - 1);
            end
            else if (ph_next == a1crp_pkg::PH_ROW2E && row_next != '0)
            begin
                out_next.ref_valid   = 1'b1;
                out_next.range_shape = 1'b1;
                out_next.first_row   = frow_next;
                out_next.first_col   = fcol_next;
                out_next.second_row  = row_m1;
                out_next.second_col  = col_m1;
            end
        end
        if (out_next.ref_valid)
        begin
            out_next.has_sheet         = sheet_next;
            out_next.sheet_quoted      = sheet_next && quoted_next;
            out_next.sheet_name_length = sheet_next ? name_next : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg     <= a1crp_pkg::PH_BEGIN;
            qp_reg     <= a1crp_pkg::Q_NONE;
            bare_reg   <= 1'b1;
            name_reg   <= '0;
            lcnt_reg   <= '0;
            dcnt_reg   <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            frow_reg   <= '0;
            fcol_reg   <= '0;
            err_reg    <= 1'b0;
            sheet_reg  <= 1'b0;
            quoted_reg <= 1'b0;
        end
        else if (take)
        begin
            if (c.last)
            begin
                ph_reg     <= a1crp_pkg::PH_BEGIN;
                qp_reg     <= a1crp_pkg::Q_NONE;
                bare_reg   <= 1'b1;
                name_reg   <= '0;
                lcnt_reg   <= '0;
                dcnt_reg   <= '0;
                col_reg    <= '0;
                row_reg    <= '0;
                frow_reg   <= '0;
                fcol_reg   <= '0;
                err_reg    <= 1'b0;
                sheet_reg  <= 1'b0;
                quoted_reg <= 1'b0;
            end
            else
            begin
                ph_reg     <= ph_next;
                qp_reg     <= qp_next;
                bare_reg   <= bare_next;
                name_reg   <= name_next;
                lcnt_reg   <= lcnt_next;
                dcnt_reg   <= dcnt_next;
                col_reg    <= col_next;
                row_reg    <= row_next;
                frow_reg   <= frow_next;
                fcol_reg   <= fcol_next;
                err_reg    <= err_next;
                sheet_reg  <= sheet_next;
                quoted_reg <= quoted_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take && c.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && c.last)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

[hw/rtl/a1_cell_reference_parser.sv]
// top level of the a1 cell reference parser
// usage:
//   text channel: one character word per cycle while text_ready is high (text_valid/text_ready),
//   last_char set on the final character of a reference string
//   result channel: one result word per string (result_valid/result_ready),
//   presented the cycle after the parser takes the last character
// path: the last character is registered in the queue and popped by the parser,
//   behind any words queued ahead of it, before result_valid is registered
// throughput: 1 character per cycle while text_ready is high, set by the
//   combinational parse step (multiply-by-26 or multiply-by-10 accumulate plus phase update)
// reset: parser returns to string start, queue and result register empty
// receiver stall: a pending result holds; the parser keeps taking characters
//   until it reaches the next last character, then the 2-word queue fills
//   and text_ready drops until the result is taken
// invalid strings yield ref_valid = 0 with every other field zero
module a1_cell_reference_parser #(
    parameter int MAX_ROWS = a1crp_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = a1crp_pkg::MAX_COLS_DEF,
    parameter int NAME_CAP = a1crp_pkg::NAME_CAP_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 text_valid,
    output logic                 text_ready,
    input  a1crp_pkg::in_word_t  text,
    output logic                 result_valid,
    input  logic                 result_ready,
    output a1crp_pkg::out_word_t result
);

    `include "a1_cell_reference_parser_macros.svh"

    a1crp_pkg::cls_t cls;
    a1crp_pkg::cls_t q_word;
    logic            q_valid;
    logic            q_ready;
    logic            span_out;

    a1crp_front u_front (
        .text (text),
        .cls  (cls)
    );

    a1crp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (text_valid),
        .push_ready (text_ready),
        .push_word  (cls),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_word   (q_word)
    );

    a1crp_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .NAME_CAP (NAME_CAP)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_word       (q_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    assign span_out = result.whole_column || result.whole_row;

    `A1CRP_ASSERT_IMPLY(a_invalid_zero, result_valid && !result.ref_valid, result == '0)
    `A1CRP_ASSERT_IMPLY(a_span_is_range, result_valid && span_out, result.range_shape)
    `A1CRP_ASSERT_NEVER(a_span_exclusive, result_valid && result.whole_column && result.whole_row)
    `A1CRP_ASSERT_IMPLY(a_quoted_has_sheet, result_valid && result.sheet_quoted, result.has_sheet)

endmodule
